@@ rtl/http_request_framer_macros.svh @@
// Assertion macros for the http_request_framer blocks.
// Each macro expects signals named clock and reset in the asserting module.
`ifndef HTTP_REQUEST_FRAMER_MACROS_SVH
`define HTTP_REQUEST_FRAMER_MACROS_SVH

// Same-cycle implication.
`define HRF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the following cycle.
`define HRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hrf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and per-byte parsing functions for the HTTP request framer.
// No dependencies.
package hrf_pkg;

   localparam int HEAD_COUNT_WIDTH = 16;
   localparam int HDR_BYTES_WIDTH  = 16;
   localparam int LEN_WIDTH        = 64;
   localparam logic [3:0] KEY_LEN  = 4'd14;
   localparam logic [3:0] KEY_POS_MAX = 4'd15;
   localparam logic [HEAD_COUNT_WIDTH-1:0] HEAD_MAX = '1;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5a;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic [1:0] {
      PH_REQUEST,
      PH_HEADERS,
      PH_BODY
   } phase_type;

   typedef enum logic [2:0] {
      VS_LEAD,
      VS_SIGN,
      VS_DIGITS,
      VS_TRAIL,
      VS_BAD
   } value_stage_type;

   typedef enum logic [1:0] {
      ST_COMPLETE,
      ST_PROTOCOL_ERR,
      ST_HEAD_LONG
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       restart;
   } req_word_type;

   typedef struct packed {
      logic                 line_empty;
      logic                 colon_seen;
      logic [3:0]           key_position;
      logic                 key_matches;
      value_stage_type      value_stage;
      logic [LEN_WIDTH-1:0] length_accumulator;
      logic                 length_seen;
      logic                 error_flag;
   } line_state_type;

   typedef struct packed {
      phase_type                   phase;
      logic                        cr_pending;
      line_state_type              line;
      logic [LEN_WIDTH-1:0]        length_value;
      logic [HEAD_COUNT_WIDTH-1:0] head_count;
      logic [LEN_WIDTH-1:0]        body_count;
   } frame_state_type;

   // lower-case "content-length"
   function automatic logic [7:0] key_char(logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h63;
         4'd1:    ch = 8'h6f;
         4'd2:    ch = 8'h6e;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6e;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2d;
         4'd8:    ch = 8'h6c;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6e;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [HDR_BYTES_WIDTH-1:0] hdr_bytes_out(
      logic [HEAD_COUNT_WIDTH-1:0] count);
      logic [HEAD_COUNT_WIDTH+HDR_BYTES_WIDTH-1:0] wide;
      wide = {{HDR_BYTES_WIDTH{1'b0}}, count};
      return wide[HDR_BYTES_WIDTH-1:0];
   endfunction

   function automatic line_state_type clear_line(line_state_type st);
      line_state_type n;
      n = st;
      n.line_empty         = 1'b1;
      n.colon_seen         = 1'b0;
      n.key_position       = '0;
      n.key_matches        = 1'b1;
      n.value_stage        = VS_LEAD;
      n.length_accumulator = '0;
      return n;
   endfunction

   function automatic frame_state_type clear_frame();
      frame_state_type f;
      f.phase               = PH_REQUEST;
      f.cr_pending          = 1'b0;
      f.line                = '0;
      f.line                = clear_line(f.line);
      f.line.length_seen    = 1'b0;
      f.line.error_flag     = 1'b0;
      f.length_value        = '0;
      f.head_count          = '0;
      f.body_count          = '0;
      return f;
   endfunction

   // One ordinary byte of a header line: key match, colon, value parse.
   function automatic line_state_type line_byte(line_state_type st, logic [7:0] c);
      line_state_type n;
      logic [7:0]     low;
      logic           digit;
      logic           blank;
      logic [LEN_WIDTH+3:0] prod;
      n     = st;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = (c == CH_SPACE) || (c == CH_TAB);
      low   = ((c >= CH_UC_A) && (c <= CH_UC_Z)) ? c + CASE_OFFSET : c;
      // acc * 10 + digit, four spare bits catch overflow
      prod  = ({4'b0, st.length_accumulator} << 3) + ({4'b0, st.length_accumulator} << 1)
            + {{LEN_WIDTH{1'b0}}, c[3:0]};
      n.line_empty = 1'b0;
      if (st.colon_seen) begin
         if (st.key_matches) begin
            unique case (st.value_stage)
               VS_LEAD: begin
                  if (blank) begin
                     n.value_stage = VS_LEAD;
                  end else if (c == CH_PLUS) begin
                     n.value_stage = VS_SIGN;
                  end else if (digit) begin
                     n.length_accumulator = {{(LEN_WIDTH-4){1'b0}}, c[3:0]};
                     n.value_stage        = VS_DIGITS;
                  end else begin
                     n.value_stage = VS_BAD;
                  end
               end
               VS_SIGN: begin
                  if (digit) begin
                     n.length_accumulator = {{(LEN_WIDTH-4){1'b0}}, c[3:0]};
                     n.value_stage        = VS_DIGITS;
                  end else begin
                     n.value_stage = VS_BAD;
                  end
               end
               VS_DIGITS: begin
                  if (digit) begin
                     if (|prod[LEN_WIDTH+3:LEN_WIDTH]) begin
                        n.value_stage = VS_BAD;
                     end else begin
                        n.length_accumulator = prod[LEN_WIDTH-1:0];
                     end
                  end else begin
                     n.value_stage = blank ? VS_TRAIL : VS_BAD;
                  end
               end
               VS_TRAIL: begin
                  if (!blank) begin
                     n.value_stage = VS_BAD;
                  end
               end
               default: n.value_stage = VS_BAD;
            endcase
         end
      end else if (c == CH_COLON) begin
         n.colon_seen = 1'b1;
         if (st.key_position == '0) begin
            n.error_flag  = 1'b1;
            n.key_matches = 1'b0;
         end else begin
            n.key_matches = st.key_matches && (st.key_position == KEY_LEN);
            if (n.key_matches) begin
               if (st.length_seen) begin
                  n.error_flag = 1'b1;
               end
               n.length_seen        = 1'b1;
               n.value_stage        = VS_LEAD;
               n.length_accumulator = '0;
            end
         end
      end else begin
         if ((st.key_position >= KEY_LEN) || (low != key_char(st.key_position))) begin
            n.key_matches = 1'b0;
         end
         if (st.key_position != KEY_POS_MAX) begin
            n.key_position = st.key_position + 4'd1;
         end
      end
      return n;
   endfunction

endpackage

@@ rtl/hrf_input_reg.sv @@
`timescale 1ns / 1ps
// Input register stage of the HTTP request framer: holds one request word.
// Depends on hrf_pkg.
module hrf_input_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_restart,
   output logic                 word_valid,
   output hrf_pkg::req_word_type word,
   input  logic                 word_take
);

   logic                  valid_ff;
   logic                  valid_in;
   hrf_pkg::req_word_type word_ff;
   hrf_pkg::req_word_type word_in;
   logic                  accept;

   // free when empty or when the held word leaves this cycle
   assign req_ready = !valid_ff || word_take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (accept) begin
         valid_in           = 1'b1;
         word_in.byte_value = req_byte_value;
         word_in.restart    = req_restart;
      end else if (word_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

@@ rtl/hrf_frame_core.sv @@
`timescale 1ns / 1ps
// Frame state and per-word parse of the HTTP request framer, with result register.
// Depends on hrf_pkg and http_request_framer_macros.svh.
`include "http_request_framer_macros.svh"
module hrf_frame_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 word_valid,
   input  hrf_pkg::req_word_type                word,
   output logic                                 word_take,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_status,
   output logic [hrf_pkg::HDR_BYTES_WIDTH-1:0]  rsp_header_bytes,
   output logic [hrf_pkg::LEN_WIDTH-1:0]        rsp_body_bytes
);

   hrf_pkg::frame_state_type frame_ff;
   hrf_pkg::frame_state_type frame_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   hrf_pkg::status_type      status_ff;
   hrf_pkg::status_type      status_in;
   logic [hrf_pkg::HDR_BYTES_WIDTH-1:0] hdr_ff;
   logic [hrf_pkg::HDR_BYTES_WIDTH-1:0] hdr_in;
   logic [hrf_pkg::LEN_WIDTH-1:0]       body_ff;
   logic [hrf_pkg::LEN_WIDTH-1:0]       body_in;
   logic                                emit;
   logic [7:0]                          b;

   assign word_take = word_valid && (!rsp_valid_ff || rsp_ready);
   assign b         = word.byte_value;

   always_comb begin
      hrf_pkg::frame_state_type s;
      hrf_pkg::frame_state_type f;
      logic [hrf_pkg::LEN_WIDTH-1:0] bc;
      s         = word.restart ? hrf_pkg::clear_frame() : frame_ff;
      f         = s;
      emit      = 1'b0;
      status_in = hrf_pkg::ST_COMPLETE;
      hdr_in    = hrf_pkg::hdr_bytes_out(s.head_count);
      body_in   = '0;
      bc        = s.body_count + 64'd1;
      if (s.phase == hrf_pkg::PH_BODY) begin
         f.body_count = bc;
         if (bc >= s.length_value) begin
            emit    = 1'b1;
            body_in = s.length_value;
         end
      end else if (s.head_count == hrf_pkg::HEAD_MAX) begin
         emit      = 1'b1;
         status_in = hrf_pkg::ST_HEAD_LONG;
         hdr_in    = hrf_pkg::hdr_bytes_out(hrf_pkg::HEAD_MAX);
      end else begin
         f.head_count = s.head_count + hrf_pkg::HEAD_COUNT_WIDTH'(1);
         hdr_in       = hrf_pkg::hdr_bytes_out(f.head_count);
         f.cr_pending = 1'b0;
         if (s.cr_pending && (b == hrf_pkg::CH_LF)) begin
            if (s.phase != hrf_pkg::PH_HEADERS) begin
               f.phase = hrf_pkg::PH_HEADERS;
               f.line  = hrf_pkg::clear_line(s.line);
            end else if (s.line.line_empty) begin
               // end of head
               if (s.line.error_flag) begin
                  emit      = 1'b1;
                  status_in = hrf_pkg::ST_PROTOCOL_ERR;
               end else if (s.length_value == '0) begin
                  emit = 1'b1;
               end else begin
                  f.phase      = hrf_pkg::PH_BODY;
                  f.body_count = '0;
               end
            end else begin
               if (!s.line.colon_seen) begin
                  f.line.error_flag = 1'b1;
               end else if (s.line.key_matches) begin
                  if ((s.line.value_stage == hrf_pkg::VS_DIGITS) ||
                      (s.line.value_stage == hrf_pkg::VS_TRAIL)) begin
                     f.length_value = s.line.length_accumulator;
                  end else begin
                     f.line.error_flag = 1'b1;
                  end
               end
               f.line = hrf_pkg::clear_line(f.line);
            end
         end else begin
            // a CR not followed by LF is a plain line character
            if (s.cr_pending && (s.phase == hrf_pkg::PH_HEADERS)) begin
               f.line = hrf_pkg::line_byte(f.line, hrf_pkg::CH_CR);
            end
            if (b == hrf_pkg::CH_CR) begin
               f.cr_pending = 1'b1;
            end else if (s.phase == hrf_pkg::PH_HEADERS) begin
               f.line = hrf_pkg::line_byte(f.line, b);
            end
         end
      end
      if (emit) begin
         f = hrf_pkg::clear_frame();
      end
      frame_in = word_take ? f : frame_ff;
   end

   always_comb begin
      if (word_take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= hrf_pkg::clear_frame();
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_take && emit) begin
         status_ff <= status_in;
         hdr_ff    <= hdr_in;
         body_ff   <= body_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_header_bytes = hdr_ff;
   assign rsp_body_bytes   = body_ff;

   `HRF_ASSERT_IMP(a_body_needs_length, frame_ff.phase == hrf_pkg::PH_BODY,
                   frame_ff.length_value != '0, "body phase with zero length")
   `HRF_ASSERT_IMP(a_body_no_error, frame_ff.phase == hrf_pkg::PH_BODY,
                   !frame_ff.line.error_flag, "body phase entered with error pending")
   `HRF_ASSERT_IMP(a_head_long_count,
                   rsp_valid_ff && (status_ff == hrf_pkg::ST_HEAD_LONG),
                   (hdr_ff == hrf_pkg::hdr_bytes_out(hrf_pkg::HEAD_MAX)) && (body_ff == '0),
                   "head-too-long word carries wrong counts")
   `HRF_ASSERT_IMP(a_error_no_body,
                   rsp_valid_ff && (status_ff == hrf_pkg::ST_PROTOCOL_ERR),
                   body_ff == '0, "error word carries a body length")
   `HRF_ASSERT_NEXT(a_emit_shows, word_take && emit, rsp_valid_ff,
                    "result word lost")

endmodule

@@ rtl/http_request_framer.sv @@
`timescale 1ns / 1ps
// http_request_framer: frames HTTP requests arriving one byte per word.
// Input channel req_*: req_byte_value is the next byte of the stream, req_restart
// drops any partial frame so that this byte opens a new one.
// Result channel rsp_*: one word per finished frame; rsp_status is complete,
// protocol error or head too long, rsp_header_bytes counts the head including
// its closing CR LF CR LF, rsp_body_bytes gives the content-length (zero if absent).
// The body is counted through the same input channel and the result appears after
// its last byte.
// rsp_valid is registered: the byte ending the frame passes from the input register
// through the combinational parse stage into the result register.
// Throughput: one byte per cycle while no result waits, set by the single parse stage
// between the two registers; the parse stage takes no byte while a finished result waits.
// Reset clears the frame state and both valid flags; the next byte starts a frame.
// When rsp_ready is low with a result held, one more byte is buffered in the input
// register and req_ready then drops until the result is taken.
// Depends on hrf_pkg, hrf_input_reg and hrf_frame_core.
module http_request_framer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_byte_value,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [hrf_pkg::HDR_BYTES_WIDTH-1:0] rsp_header_bytes,
   output logic [hrf_pkg::LEN_WIDTH-1:0]       rsp_body_bytes
);

   logic                  word_valid;
   logic                  word_take;
   hrf_pkg::req_word_type word;

   hrf_input_reg u_input_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .req_restart    (req_restart),
      .word_valid     (word_valid),
      .word           (word),
      .word_take      (word_take)
   );

   hrf_frame_core u_frame_core (
      .clock            (clock),
      .reset            (reset),
      .word_valid       (word_valid),
      .word             (word),
      .word_take        (word_take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_header_bytes (rsp_header_bytes),
      .rsp_body_bytes   (rsp_body_bytes)
   );

endmodule
